/* design/mpmc_pkg.sv */
// ----------------------------------------------------------------------------
// mpmc_pkg: shared types and codes of the multi-pattern match counter
// Operation codes, result codes and the command/status records that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mpmc_pkg;

    // operation codes carried by an input beat
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_BUILD  = 3'd2;
    localparam logic [2:0] OP_MATCH  = 3'd3;
    localparam logic [2:0] OP_REPORT = 3'd4;

    // result kinds and status codes
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_FULL     = 1'b1;

    // datapath micro-operations
    typedef enum logic [4:0] {
        C_NOP,
        C_ACCEPT,
        C_CLEAR,
        C_LOAD_ACK,
        C_INS_RD,
        C_INS_HIT,
        C_INS_FULL,
        C_INS_NEW,
        C_INS_ZROW,
        C_B_INIT,
        C_LOAD_PROW,
        C_NEXT_I,
        C_ENQ_ROOT,
        C_START_FAIL,
        C_F_RD,
        C_ENQ_FOUND,
        C_F_STEP,
        C_Q_RD,
        C_P_RD,
        C_M_RD,
        C_M_HIT,
        C_M_MISS,
        C_M_STEP,
        C_O_RD,
        C_O_STEP,
        C_R_INIT,
        C_R_SCAN,
        C_R_REWIND,
        C_R_SKIP,
        C_R_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic in_ready;
    } t_ctrl;

    typedef struct packed {
        logic       in_valid;
        logic [2:0] in_op;
        logic       sym_bad;
        logic       sym_child_nz;
        logic       table_full;
        logic       scan_end;
        logic       scan_zero;
        logic       is_root;
        logic       fail_child_nz;
        logic       t_zero;
        logic       q_empty;
        logic       p_zero;
        logic       chain_end;
        logic       rep_done;
        logic       rep_eq;
        logic       rep_last;
        logic       out_free;
    } t_status;

endpackage

`default_nettype wire

/* design/mpmc_in_if.sv */
// ----------------------------------------------------------------------------
// mpmc_in_if: operation channel
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpmc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [4:0] symbol;
    logic [4:0] pattern_id;
    logic       pattern_end;

    modport source (output valid, operation, symbol, pattern_id, pattern_end,
                    input ready);
    modport sink   (input valid, operation, symbol, pattern_id, pattern_end,
                    output ready);
endinterface

`default_nettype wire

/* design/mpmc_out_if.sv */
// ----------------------------------------------------------------------------
// mpmc_out_if: result channel
// Valid/ready channel carrying one acknowledgement or report beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpmc_out_if #(
    parameter int COUNT_BITS = 24
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic                  status;
    logic [4:0]            best_pattern;
    logic [COUNT_BITS-1:0] best_count;
    logic                  last;

    modport source (output valid, kind, status, best_pattern, best_count, last,
                    input ready);
    modport sink   (input valid, kind, status, best_pattern, best_count, last,
                    output ready);
endinterface

`default_nettype wire

/* design/mpmc_datapath.sv */
// ----------------------------------------------------------------------------
// mpmc_datapath: trie memories, cursors, counters and result register
// Executes one micro-operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module mpmc_datapath #(
    parameter int NODES        = 4096,
    parameter int MAX_PATTERNS = 32,
    parameter int ALPHABET     = 26,
    parameter int COUNT_BITS   = 24
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [5:0]            i_cfg_data,
    input  mpmc_pkg::t_ctrl      i_ctrl,
    output mpmc_pkg::t_status    o_status,
    mpmc_in_if.sink              i_in,
    mpmc_out_if.source           o_out
);
    import mpmc_pkg::*;

    localparam int NB  = $clog2(NODES);
    localparam int NCW = NB + 1;
    localparam int SB  = $clog2(ALPHABET);
    localparam int ICW = $clog2(ALPHABET + 1);
    localparam int PB  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CW  = $clog2(MAX_PATTERNS + 1);
    localparam int TB  = CW;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef logic [ALPHABET-1:0][NB-1:0] t_row;

    // memories
    t_row            child_mem [NODES];
    logic [NB-1:0]   fail_mem  [NODES];
    logic [TB-1:0]   tag_mem   [NODES];
    logic [NB-1:0]   queue_mem [NODES];

    t_row            r_child_q;
    logic [NB-1:0]   r_fail_q;
    logic [TB-1:0]   r_tag_q;
    logic [NB-1:0]   r_queue_q;

    // latched operation
    logic [4:0]      r_sym;
    logic [4:0]      r_pid;
    logic            r_end;
    logic            r_status;

    // trie state
    logic [NCW-1:0]  r_nodes_used;
    logic [NB-1:0]   r_ins_cur;
    logic [NB-1:0]   r_match_cur;
    logic [NB-1:0]   r_new;

    // build and match work registers
    logic [NB-1:0]   r_p;
    logic [NB-1:0]   r_t;
    logic [NB-1:0]   r_c;
    t_row            r_prow;
    logic [NB-1:0]   r_pfail;
    logic [ICW-1:0]  r_i;
    logic            r_root;
    logic [NCW-1:0]  r_head;
    logic [NCW-1:0]  r_tail;

    // counts and report
    logic [COUNT_BITS-1:0] r_hits [MAX_PATTERNS];
    logic [5:0]            r_pat_cnt;
    logic [CW-1:0]         r_ridx;
    logic [COUNT_BITS-1:0] r_best;
    logic [CW-1:0]         r_lastidx;

    // result register
    logic                  r_out_valid;
    logic                  r_kind;
    logic                  r_ostatus;
    logic [4:0]            r_obest_p;
    logic [COUNT_BITS-1:0] r_obest_c;
    logic                  r_olast;

    // combinational helpers
    logic [SB-1:0]         sym_idx;
    logic [SB-1:0]         i_idx;
    logic [NB-1:0]         sym_child;
    logic [NB-1:0]         i_child;
    logic [NB-1:0]         prow_c;
    logic                  pid_ok;
    logic [TB-1:0]         tag_val;
    logic [TB-1:0]         tag_m1;
    logic [PB-1:0]         hidx;
    logic [CW-1:0]         npat;
    logic [COUNT_BITS-1:0] hits_rep;
    logic                  out_free;
    logic                  in_acc;
    logic                  q_room;
    t_row                  ins_row;

    logic                  child_we;
    logic [NB-1:0]         child_waddr;
    t_row                  child_wdata;
    logic [NB-1:0]         child_raddr;
    logic                  fail_we;
    logic [NB-1:0]         fail_waddr;
    logic [NB-1:0]         fail_wdata;
    logic [NB-1:0]         fail_raddr;
    logic                  tag_we;
    logic [NB-1:0]         tag_waddr;
    logic [TB-1:0]         tag_wdata;
    logic                  queue_we;
    logic [NB-1:0]         queue_wdata;

    assign sym_idx   = SB'(r_sym);
    assign i_idx     = r_i[SB-1:0];
    assign sym_child = r_child_q[sym_idx];
    assign i_child   = r_child_q[i_idx];
    assign prow_c    = r_prow[i_idx];
    assign pid_ok    = 7'(r_pid) < 7'(MAX_PATTERNS);
    assign tag_val   = TB'(7'(r_pid) + 7'd1);
    assign tag_m1    = r_tag_q - TB'(1);
    assign hidx      = PB'(tag_m1);
    assign hits_rep  = r_hits[PB'(r_ridx)];
    assign out_free  = !r_out_valid || o_out.ready;
    assign in_acc    = i_in.valid && i_ctrl.in_ready;
    assign q_room    = r_tail < NCW'(NODES);

    always_comb begin
        if (r_pat_cnt == 6'd0) begin
            npat = CW'(1);
        end else if (7'(r_pat_cnt) > 7'(MAX_PATTERNS)) begin
            npat = CW'(MAX_PATTERNS);
        end else begin
            npat = CW'(r_pat_cnt);
        end
    end

    always_comb begin
        ins_row          = r_child_q;
        ins_row[sym_idx] = r_nodes_used[NB-1:0];
    end

    // memory address and write selection
    always_comb begin
        child_we    = 1'b0;
        child_waddr = r_ins_cur;
        child_wdata = ins_row;
        child_raddr = r_p;
        fail_we     = 1'b0;
        fail_waddr  = r_c;
        fail_wdata  = i_child;
        fail_raddr  = r_p;
        tag_we      = 1'b0;
        tag_waddr   = sym_child;
        tag_wdata   = tag_val;
        queue_we    = 1'b0;
        queue_wdata = r_c;
        case (i_ctrl.cmd)
            C_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = '0;
                child_wdata = '0;
            end
            C_INS_RD: begin
                child_raddr = r_ins_cur;
            end
            C_INS_HIT: begin
                tag_we = r_end && pid_ok;
            end
            C_INS_NEW: begin
                child_we   = 1'b1;
                fail_we    = 1'b1;
                fail_waddr = r_nodes_used[NB-1:0];
                fail_wdata = '0;
                tag_we     = 1'b1;
                tag_waddr  = r_nodes_used[NB-1:0];
                tag_wdata  = (r_end && pid_ok) ? tag_val : '0;
            end
            C_INS_ZROW: begin
                child_we    = 1'b1;
                child_waddr = r_new;
                child_wdata = '0;
            end
            C_B_INIT: begin
                child_raddr = '0;
            end
            C_ENQ_ROOT: begin
                fail_we     = 1'b1;
                fail_waddr  = prow_c;
                fail_wdata  = '0;
                queue_we    = q_room;
                queue_wdata = prow_c;
            end
            C_F_RD: begin
                child_raddr = r_t;
                fail_raddr  = r_t;
            end
            C_ENQ_FOUND: begin
                fail_we  = 1'b1;
                queue_we = q_room;
            end
            C_P_RD: begin
                child_raddr = r_queue_q;
                fail_raddr  = r_queue_q;
            end
            C_O_RD: begin
                fail_raddr = r_t;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (child_we) begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (fail_we) begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (queue_we) begin
            queue_mem[r_tail[NB-1:0]] <= queue_wdata;
        end
        r_child_q <= child_mem[child_raddr];
        r_fail_q  <= fail_mem[fail_raddr];
        r_tag_q   <= tag_mem[r_t];
        r_queue_q <= queue_mem[r_head[NB-1:0]];
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_used <= NCW'(1);
            r_ins_cur    <= '0;
            r_match_cur  <= '0;
            r_status     <= ST_OK;
            r_head       <= '0;
            r_tail       <= '0;
            r_root       <= 1'b1;
            r_pat_cnt    <= 6'd1;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < MAX_PATTERNS; k++) begin
                r_hits[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_pat_cnt <= i_cfg_data;
            end
            // drop the taken beat unless a new one loads in the same cycle
            if (r_out_valid && o_out.ready && i_ctrl.cmd != C_LOAD_ACK &&
                i_ctrl.cmd != C_R_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctrl.cmd)
                C_ACCEPT: begin
                    if (in_acc) begin
                        r_sym    <= i_in.symbol;
                        r_pid    <= i_in.pattern_id;
                        r_end    <= i_in.pattern_end;
                        r_status <= ST_OK;
                        r_p      <= r_match_cur;
                    end
                end
                C_CLEAR: begin
                    r_nodes_used <= NCW'(1);
                    r_ins_cur    <= '0;
                    r_match_cur  <= '0;
                    for (int k = 0; k < MAX_PATTERNS; k++) begin
                        r_hits[k] <= '0;
                    end
                end
                C_LOAD_ACK: begin
                    r_out_valid <= 1'b1;
                    r_kind      <= KIND_ACK;
                    r_ostatus   <= r_status;
                    r_obest_p   <= '0;
                    r_obest_c   <= '0;
                    r_olast     <= 1'b1;
                end
                C_INS_HIT: begin
                    r_ins_cur <= r_end ? '0 : sym_child;
                end
                C_INS_FULL: begin
                    r_ins_cur <= '0;
                    r_status  <= ST_FULL;
                end
                C_INS_NEW: begin
                    r_new        <= r_nodes_used[NB-1:0];
                    r_nodes_used <= r_nodes_used + NCW'(1);
                    r_ins_cur    <= r_end ? '0 : r_nodes_used[NB-1:0];
                end
                C_B_INIT: begin
                    r_head      <= '0;
                    r_tail      <= '0;
                    r_root      <= 1'b1;
                    r_match_cur <= '0;
                end
                C_LOAD_PROW: begin
                    r_prow  <= r_child_q;
                    r_pfail <= r_fail_q;
                    r_i     <= '0;
                end
                C_NEXT_I: begin
                    r_i <= r_i + ICW'(1);
                end
                C_ENQ_ROOT, C_ENQ_FOUND: begin
                    r_i <= r_i + ICW'(1);
                    if (q_room) begin
                        r_tail <= r_tail + NCW'(1);
                    end
                end
                C_START_FAIL: begin
                    r_c <= prow_c;
                    r_t <= r_pfail;
                end
                C_F_STEP: begin
                    r_t <= r_fail_q;
                end
                C_Q_RD: begin
                    r_head <= r_head + NCW'(1);
                end
                C_P_RD: begin
                    r_root <= 1'b0;
                end
                C_M_HIT: begin
                    r_match_cur <= sym_child;
                    r_t         <= sym_child;
                end
                C_M_MISS: begin
                    r_match_cur <= '0;
                end
                C_M_STEP: begin
                    r_p <= r_fail_q;
                end
                C_O_STEP: begin
                    if (r_tag_q != '0 && r_hits[hidx] != COUNT_MAX) begin
                        r_hits[hidx] <= r_hits[hidx] + COUNT_BITS'(1);
                    end
                    r_t <= r_fail_q;
                end
                C_R_INIT: begin
                    r_ridx    <= '0;
                    r_best    <= '0;
                    r_lastidx <= '0;
                end
                C_R_SCAN: begin
                    if (hits_rep > r_best) begin
                        r_best    <= hits_rep;
                        r_lastidx <= r_ridx;
                    end else if (hits_rep == r_best) begin
                        r_lastidx <= r_ridx;
                    end
                    r_ridx <= r_ridx + CW'(1);
                end
                C_R_REWIND: begin
                    r_ridx <= '0;
                end
                C_R_SKIP: begin
                    r_ridx <= r_ridx + CW'(1);
                end
                C_R_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_kind      <= KIND_REPORT;
                    r_ostatus   <= ST_OK;
                    r_obest_p   <= 5'(r_ridx);
                    r_obest_c   <= r_best;
                    r_olast     <= (r_ridx == r_lastidx);
                    r_ridx      <= r_ridx + CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready         = i_ctrl.in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.status       = r_ostatus;
    assign o_out.best_pattern = r_obest_p;
    assign o_out.best_count   = r_obest_c;
    assign o_out.last         = r_olast;

    always_comb begin
        o_status.in_valid      = i_in.valid;
        o_status.in_op         = i_in.operation;
        o_status.sym_bad       = 9'(r_sym) >= 9'(ALPHABET);
        o_status.sym_child_nz  = sym_child != '0;
        o_status.table_full    = r_nodes_used >= NCW'(NODES);
        o_status.scan_end      = r_i == ICW'(ALPHABET);
        o_status.scan_zero     = prow_c == '0;
        o_status.is_root       = r_root;
        o_status.fail_child_nz = i_child != '0;
        o_status.t_zero        = r_t == '0;
        o_status.q_empty       = r_head == r_tail;
        o_status.p_zero        = r_p == '0;
        o_status.chain_end     = r_fail_q == '0;
        o_status.rep_done      = r_ridx == npat;
        o_status.rep_eq        = hits_rep == r_best;
        o_status.rep_last      = r_ridx == r_lastidx;
        o_status.out_free      = out_free;
    end

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail >= r_head)
        else $error("bfs queue head passed tail");

    a_nodes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nodes_used != '0 && r_nodes_used <= NCW'(NODES))
        else $error("node count out of range");

    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.cmd == C_INS_NEW |=> r_nodes_used <= NCW'(NODES) && r_new != '0)
        else $error("node allocated with table full");

endmodule

`default_nettype wire

/* design/mpmc_controller.sv */
// ----------------------------------------------------------------------------
// mpmc_controller: operation sequencer
// One-hot state machine that steps the datapath through each operation.
// ----------------------------------------------------------------------------
`default_nettype none

module mpmc_controller (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  mpmc_pkg::t_status i_status,
    output mpmc_pkg::t_ctrl   o_ctrl
);
    import mpmc_pkg::*;

    typedef enum logic [20:0] {
        S_INIT     = 21'h000001,
        S_IDLE     = 21'h000002,
        S_CLEAR    = 21'h000004,
        S_ACK      = 21'h000008,
        S_INS_RD   = 21'h000010,
        S_INS_CHK  = 21'h000020,
        S_INS_ZROW = 21'h000040,
        S_B_INIT   = 21'h000080,
        S_B_LROW   = 21'h000100,
        S_B_SCAN   = 21'h000200,
        S_B_NEXT   = 21'h000400,
        S_B_QW     = 21'h000800,
        S_B_FRD    = 21'h001000,
        S_B_FCHK   = 21'h002000,
        S_M_RD     = 21'h004000,
        S_M_CHK    = 21'h008000,
        S_O_RD     = 21'h010000,
        S_O_CHK    = 21'h020000,
        S_R_INIT   = 21'h040000,
        S_R_SCAN   = 21'h080000,
        S_R_EMIT   = 21'h100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_ctrl.cmd      = C_NOP;
        o_ctrl.in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_ctrl.cmd = C_CLEAR;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.cmd      = C_ACCEPT;
                if (i_status.in_valid) begin
                    case (i_status.in_op)
                        OP_CLEAR:  n_state = S_CLEAR;
                        OP_INSERT: n_state = S_INS_RD;
                        OP_BUILD:  n_state = S_B_INIT;
                        OP_MATCH:  n_state = S_M_RD;
                        OP_REPORT: n_state = S_R_INIT;
                        default:   n_state = S_ACK;
                    endcase
                end
            end
            S_CLEAR: begin
                o_ctrl.cmd = C_CLEAR;
                n_state    = S_ACK;
            end
            S_ACK: begin
                if (i_status.out_free) begin
                    o_ctrl.cmd = C_LOAD_ACK;
                    n_state    = S_IDLE;
                end
            end
            S_INS_RD: begin
                if (i_status.sym_bad) begin
                    n_state = S_ACK;
                end else begin
                    o_ctrl.cmd = C_INS_RD;
                    n_state    = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (i_status.sym_child_nz) begin
                    o_ctrl.cmd = C_INS_HIT;
                    n_state    = S_ACK;
                end else if (i_status.table_full) begin
                    o_ctrl.cmd = C_INS_FULL;
                    n_state    = S_ACK;
                end else begin
                    o_ctrl.cmd = C_INS_NEW;
                    n_state    = S_INS_ZROW;
                end
            end
            S_INS_ZROW: begin
                o_ctrl.cmd = C_INS_ZROW;
                n_state    = S_ACK;
            end
            S_B_INIT: begin
                o_ctrl.cmd = C_B_INIT;
                n_state    = S_B_LROW;
            end
            S_B_LROW: begin
                o_ctrl.cmd = C_LOAD_PROW;
                n_state    = S_B_SCAN;
            end
            S_B_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_B_NEXT;
                end else if (i_status.scan_zero) begin
                    o_ctrl.cmd = C_NEXT_I;
                end else if (i_status.is_root) begin
                    o_ctrl.cmd = C_ENQ_ROOT;
                end else begin
                    o_ctrl.cmd = C_START_FAIL;
                    n_state    = S_B_FRD;
                end
            end
            S_B_FRD: begin
                o_ctrl.cmd = C_F_RD;
                n_state    = S_B_FCHK;
            end
            S_B_FCHK: begin
                if (i_status.fail_child_nz || i_status.t_zero) begin
                    o_ctrl.cmd = C_ENQ_FOUND;
                    n_state    = S_B_SCAN;
                end else begin
                    o_ctrl.cmd = C_F_STEP;
                    n_state    = S_B_FRD;
                end
            end
            S_B_NEXT: begin
                if (i_status.q_empty) begin
                    n_state = S_ACK;
                end else begin
                    o_ctrl.cmd = C_Q_RD;
                    n_state    = S_B_QW;
                end
            end
            S_B_QW: begin
                o_ctrl.cmd = C_P_RD;
                n_state    = S_B_LROW;
            end
            S_M_RD: begin
                if (i_status.sym_bad) begin
                    o_ctrl.cmd = C_M_MISS;
                    n_state    = S_ACK;
                end else begin
                    o_ctrl.cmd = C_M_RD;
                    n_state    = S_M_CHK;
                end
            end
            S_M_CHK: begin
                if (i_status.sym_child_nz) begin
                    o_ctrl.cmd = C_M_HIT;
                    n_state    = S_O_RD;
                end else if (i_status.p_zero) begin
                    o_ctrl.cmd = C_M_MISS;
                    n_state    = S_ACK;
                end else begin
                    o_ctrl.cmd = C_M_STEP;
                    n_state    = S_M_RD;
                end
            end
            S_O_RD: begin
                o_ctrl.cmd = C_O_RD;
                n_state    = S_O_CHK;
            end
            S_O_CHK: begin
                o_ctrl.cmd = C_O_STEP;
                n_state    = i_status.chain_end ? S_ACK : S_O_RD;
            end
            S_R_INIT: begin
                o_ctrl.cmd = C_R_INIT;
                n_state    = S_R_SCAN;
            end
            S_R_SCAN: begin
                if (i_status.rep_done) begin
                    o_ctrl.cmd = C_R_REWIND;
                    n_state    = S_R_EMIT;
                end else begin
                    o_ctrl.cmd = C_R_SCAN;
                end
            end
            S_R_EMIT: begin
                if (!i_status.rep_eq) begin
                    o_ctrl.cmd = C_R_SKIP;
                end else if (i_status.out_free) begin
                    o_ctrl.cmd = C_R_EMIT;
                    if (i_status.rep_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.cmd == C_LOAD_ACK || o_ctrl.cmd == C_R_EMIT) |-> i_status.out_free)
        else $error("result loaded over a pending beat");

    a_accept_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.in_ready && i_status.in_valid) |=> r_state != S_IDLE)
        else $error("accepted beat not processed");

    a_zrow_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS_ZROW |-> $past(o_ctrl.cmd) == C_INS_NEW)
        else $error("row clear without node allocation");

endmodule

`default_nettype wire

/* design/multi_pattern_match_counter_core.sv */
// ----------------------------------------------------------------------------
// multi_pattern_match_counter_core: Aho-Corasick pattern occurrence counter
// Trie build, failure links, overlapping match counting and max-count report.
// ----------------------------------------------------------------------------
// One operation beat is taken at a time; a result beat waits in the output
// register while the next operation is already accepted. After reset the
// block clears the root row before it takes the first beat. The child-row
// memory has one read and one write port. Clear zeroes the root row; insert
// reads the current node's row and zeroes the child row of a newly allocated
// node in place; match follows failure links until a child is found or the
// root is reached, then walks the output chain; build visits every node
// breadth-first, scanning each alphabet symbol and searching failure links
// for each child; report finds the maximum in one pass over the patterns and
// sends the entries equal to it in a second pass. Each result beat leaves
// the output register one per cycle when the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_match_counter_core #(
    parameter int NODES        = 4096,
    parameter int MAX_PATTERNS = 32,
    parameter int ALPHABET     = 26,
    parameter int COUNT_BITS   = 24
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [5:0]  i_cfg_data,
    mpmc_in_if.sink    i_in,
    mpmc_out_if.source o_out
);
    import mpmc_pkg::*;

    // command from the sequencer, flags back from the datapath
    t_ctrl   ctrl;
    t_status status;

    // sequence each operation as a string of datapath micro-steps
    mpmc_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // hold the trie, the counters and the result register
    mpmc_datapath #(
        .NODES        (NODES),
        .MAX_PATTERNS (MAX_PATTERNS),
        .ALPHABET     (ALPHABET),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (ctrl),
        .o_status   (status),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
